// ===== rtl/stwim_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot table with id map: shared definitions
// Field widths, command codes, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package stwim_pkg;

  localparam int unsigned CmdW       = 3;
  localparam int unsigned IdW        = 32;
  localparam int unsigned SlotIdxW   = 6;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned SlotCountW = 7;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 7;
  localparam int unsigned MaxLive    = 128;
  localparam int unsigned LiveW      = 8;

  typedef logic [CmdW-1:0]    cmd_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [CfgIndexW-1:0] cfg_index_t;

  localparam cmd_t CMD_ALLOC  = 3'd0;
  localparam cmd_t CMD_FREE   = 3'd1;
  localparam cmd_t CMD_SET_ID = 3'd2;
  localparam cmd_t CMD_LOOKUP = 3'd3;
  localparam cmd_t CMD_NEXT   = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NO_FREE   = 2'd1;
  localparam status_t ST_BEYOND    = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

  localparam cfg_index_t CFG_SLOT_COUNT  = 2'd0;
  localparam cfg_index_t CFG_CLIENT_ROLE = 2'd1;

  localparam logic [SlotCountW-1:0] SlotCountReset = 7'd64;
  localparam logic [IdW-1:0]        IdCounterReset = 32'd1;
  localparam logic [IdW-1:0]        ClientId       = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ===== rtl/slot_table_with_id_map_unit.sv =====
// ----------------------------------------------------------------------------
// Slot table with id map
// Keeps an in-use bit and an owner id per slot, an id-to-slot map and an id
// counter, and executes allocate, free, set-id, lookup and next-id commands.
//
// A command is taken at a rising edge with start high and busy low. Exactly
// one result follows, shown for one cycle with result_valid_o high; the
// receiver cannot stall it. Lookups of an in-range id pass through EXEC and
// CHECK, because the map read and the owner id read are two dependent
// synchronous memory reads; all other commands finish in EXEC, which follows
// the map read and does the single write-back. A new command may be started
// in the cycle in which the previous result is shown, not while one is in
// flight. Configuration writes use a separate channel that is always ready;
// the user must ensure they are made only while no command is in flight;
// the block does not enforce this. Reset empties all slots, sets the id
// counter to one and restores the register defaults. The map memory needs
// no clearing pass: a lookup only hits on a busy slot whose owner id equals
// the id, and such an owner id was always mapped when it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_table_with_id_map_unit #(
  parameter int unsigned SLOTS    = 64,
  parameter int unsigned ID_SLOTS = 1024
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [stwim_pkg::CmdW-1:0]            cmd_i,
  input  wire  signed [stwim_pkg::IdW-1:0]      entity_id_i,
  input  wire  [stwim_pkg::SlotIdxW-1:0]        slot_index_i,
  output logic                                  result_valid_o,
  output logic [stwim_pkg::StatusW-1:0]         status_o,
  output logic [stwim_pkg::SlotIdxW-1:0]        found_slot_o,
  output logic signed [stwim_pkg::IdW-1:0]      issued_id_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [stwim_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  wire  [stwim_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned Used = (SLOTS < stwim_pkg::MaxLive) ? SLOTS : stwim_pkg::MaxLive;
  localparam int unsigned SlotW = $clog2(Used);
  localparam int unsigned MapW  = $clog2(ID_SLOTS);
  localparam int unsigned IdW   = stwim_pkg::IdW;
  localparam int unsigned LiveW = stwim_pkg::LiveW;
  localparam int unsigned SlotIdxW = stwim_pkg::SlotIdxW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK
  } state_e;

  state_e state_q;
  state_e state_d;

  logic [stwim_pkg::CmdW-1:0]       cmd_q;
  logic [IdW-1:0]                   id_q;
  logic [stwim_pkg::SlotIdxW-1:0]   idx_q;
  logic [SlotW-1:0]                 look_slot_q;
  logic [Used-1:0]                  slot_busy_q;
  logic [Used-1:0]                  slot_busy_d;
  logic [IdW-1:0]                   id_counter_q;
  logic [IdW-1:0]                   id_counter_d;
  logic [stwim_pkg::SlotCountW-1:0] slot_count_q;
  logic                             client_role_q;

  logic                             result_valid_d;
  logic [stwim_pkg::StatusW-1:0]    status_d;
  logic [SlotIdxW-1:0]              found_slot_d;
  logic [IdW-1:0]                   issued_id_d;

  logic [IdW-1:0]   owner_data [Used];
  logic [SlotW-1:0] map_mem [ID_SLOTS];
  logic [SlotW-1:0] map_rdata_q;
  logic [IdW-1:0]   owner_rdata_q;

  logic             accept;
  logic [LiveW-1:0] live_n;
  logic             free_found;
  logic [SlotW-1:0] free_slot;
  logic             id_neg;
  logic             id_in_map;
  logic             id_beyond;
  logic             idx_live;
  logic [SlotW-1:0] idx_slot;
  logic             owner_we;
  logic [SlotW-1:0] owner_waddr;
  logic [IdW-1:0]   owner_wdata;
  logic             map_we;
  logic [SlotW-1:0] map_wdata;
  logic             look_hit;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign live_n = (slot_count_q < LiveW'(Used)) ? LiveW'(slot_count_q) : LiveW'(Used);

  assign id_neg    = id_q[IdW-1];
  assign id_in_map = !id_neg && (id_q < IdW'(ID_SLOTS));
  assign id_beyond = !id_neg && !id_in_map;
  assign idx_live  = (LiveW'(idx_q) < live_n);
  assign idx_slot  = SlotW'(idx_q);

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = Used - 1; i >= 0; i--) begin
      if ((i < int'(live_n)) && !slot_busy_q[i]) begin
        free_found = 1'b1;
        free_slot  = SlotW'(i);
      end
    end
  end

  always_comb begin
    owner_we    = 1'b0;
    owner_waddr = idx_slot;
    owner_wdata = id_q;
    map_we      = 1'b0;
    map_wdata   = idx_slot;
    if (state_q == S_EXEC) begin
      case (cmd_q)
        stwim_pkg::CMD_ALLOC: begin
          owner_we    = free_found;
          owner_waddr = free_slot;
          map_we      = free_found && id_in_map;
          map_wdata   = free_slot;
        end
        stwim_pkg::CMD_FREE: begin
          owner_we    = idx_live;
          owner_wdata = '0;
        end
        stwim_pkg::CMD_SET_ID: begin
          owner_we = idx_live;
          map_we   = idx_live && id_in_map;
        end
        default: begin
          owner_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[id_q[MapW-1:0]] <= map_wdata;
    end
    if (accept) begin
      map_rdata_q <= map_mem[entity_id_i[MapW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_data[owner_waddr] <= owner_wdata;
    end
    owner_rdata_q <= owner_data[map_rdata_q];
  end

  assign look_hit = (LiveW'(look_slot_q) < live_n) && slot_busy_q[look_slot_q]
                    && (owner_rdata_q == id_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q  <= stwim_pkg::SlotCountReset;
      client_role_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        stwim_pkg::CFG_SLOT_COUNT:  slot_count_q  <= cfg_data_i;
        stwim_pkg::CFG_CLIENT_ROLE: client_role_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      id_q  <= entity_id_i;
      idx_q <= slot_index_i;
    end
    if (state_q == S_EXEC) begin
      look_slot_q <= map_rdata_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    result_valid_d = 1'b0;
    status_d       = status_o;
    found_slot_d   = found_slot_o;
    issued_id_d    = issued_id_o;
    slot_busy_d    = slot_busy_q;
    id_counter_d   = id_counter_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d        = S_IDLE;
        result_valid_d = 1'b1;
        status_d       = stwim_pkg::ST_OK;
        found_slot_d   = '0;
        issued_id_d    = '0;
        case (cmd_q)
          stwim_pkg::CMD_ALLOC: begin
            if (!free_found) begin
              status_d = stwim_pkg::ST_NO_FREE;
            end else if (id_beyond) begin
              status_d = stwim_pkg::ST_BEYOND;
            end else begin
              slot_busy_d[free_slot] = 1'b1;
              found_slot_d           = SlotIdxW'(free_slot);
            end
          end
          stwim_pkg::CMD_FREE: begin
            if (idx_live) begin
              slot_busy_d[idx_slot] = 1'b0;
            end
          end
          stwim_pkg::CMD_SET_ID: begin
            if (idx_live && id_beyond) begin
              status_d = stwim_pkg::ST_BEYOND;
            end
          end
          stwim_pkg::CMD_LOOKUP: begin
            if (id_neg) begin
              status_d = stwim_pkg::ST_NOT_FOUND;
            end else if (id_beyond) begin
              status_d = stwim_pkg::ST_BEYOND;
            end else begin
              state_d        = S_CHECK;
              result_valid_d = 1'b0;
            end
          end
          stwim_pkg::CMD_NEXT: begin
            if (client_role_q) begin
              issued_id_d = stwim_pkg::ClientId;
            end else begin
              issued_id_d  = id_counter_q;
              id_counter_d = id_counter_q + IdW'(1);
            end
          end
          default: ;
        endcase
      end
      S_CHECK: begin
        state_d        = S_IDLE;
        result_valid_d = 1'b1;
        issued_id_d    = '0;
        if (look_hit) begin
          status_d     = stwim_pkg::ST_OK;
          found_slot_d = SlotIdxW'(look_slot_q);
        end else begin
          status_d     = stwim_pkg::ST_NOT_FOUND;
          found_slot_d = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slot_busy_q    <= '0;
      id_counter_q   <= stwim_pkg::IdCounterReset;
      result_valid_o <= 1'b0;
      status_o       <= stwim_pkg::ST_OK;
      found_slot_o   <= '0;
      issued_id_o    <= '0;
    end else begin
      state_q        <= state_d;
      slot_busy_q    <= slot_busy_d;
      id_counter_q   <= id_counter_d;
      result_valid_o <= result_valid_d;
      status_o       <= status_d;
      found_slot_o   <= found_slot_d;
      issued_id_o    <= issued_id_d;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_slot_table_with_id_map_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the slot table with id map
// Drives allocate, free, set-id, lookup and next-id commands through the
// start/busy port, with register writes between phases. It tracks its own
// copy of the slot table, the id map, the id counter and the registers, and
// checks every result field against that copy or against a value typed in
// the directed table. A directed table comes first, then random phases with
// varied slot counts and roles.
// ----------------------------------------------------------------------------

module tb_slot_table_with_id_map_unit;

  localparam int unsigned SlotsBuilt    = 64;
  localparam int unsigned IdSlots       = 1024;
  localparam int unsigned MapAddrW      = 10;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 200;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned IdW           = stwim_pkg::IdW;
  localparam int unsigned SlotIdxW      = stwim_pkg::SlotIdxW;
  localparam int unsigned CfgDataW      = stwim_pkg::CfgDataW;
  localparam stwim_pkg::cmd_t CmdUndefLow  = 3'd5;
  localparam stwim_pkg::cmd_t CmdUndefHigh = 3'd7;

  typedef struct packed {
    stwim_pkg::cmd_t     cmd;
    logic [IdW-1:0]      entity_id;
    logic [SlotIdxW-1:0] slot_index;
  } command_t;

  typedef struct packed {
    stwim_pkg::status_t  status;
    logic [SlotIdxW-1:0] found_slot;
    logic [IdW-1:0]      issued_id;
  } outcome_t;

  typedef struct packed {
    logic                  is_cfg;
    stwim_pkg::cfg_index_t cfg_index;
    logic [CfgDataW-1:0]   cfg_data;
    command_t              command;
    logic                  checked;
    outcome_t              typed_result;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [stwim_pkg::CmdW-1:0]      cmd_i;
  logic [IdW-1:0]      entity_id_i;
  logic [SlotIdxW-1:0] slot_index_i;
  logic                result_valid_o;
  logic [stwim_pkg::StatusW-1:0]   status_o;
  logic [SlotIdxW-1:0] found_slot_o;
  logic [IdW-1:0]      issued_id_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [stwim_pkg::CfgIndexW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  logic                slot_in_use [SlotsBuilt];
  logic [IdW-1:0]      slot_owner [SlotsBuilt];
  logic [SlotIdxW-1:0] id_to_slot [IdSlots];
  logic [IdW-1:0]      next_issue_id;
  logic [stwim_pkg::SlotCountW-1:0] model_slot_count;
  logic                model_client_role;

  outcome_t    pending_results [$];
  plan_row_t   directed_plan [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  slot_table_with_id_map_unit #(
    .SLOTS    (SlotsBuilt),
    .ID_SLOTS (IdSlots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .entity_id_i    (entity_id_i),
    .slot_index_i   (slot_index_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .found_slot_o   (found_slot_o),
    .issued_id_o    (issued_id_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned usable_slots();
    return (model_slot_count < SlotsBuilt) ? int'(model_slot_count) : SlotsBuilt;
  endfunction

  function automatic outcome_t execute_slot_command(command_t c);
    outcome_t            r;
    int unsigned         live;
    int unsigned         i;
    logic [SlotIdxW-1:0] s;
    logic                mappable;
    r        = '0;
    live     = usable_slots();
    mappable = !c.entity_id[IdW-1] && (c.entity_id < IdSlots);
    case (c.cmd)
      stwim_pkg::CMD_ALLOC: begin
        i = 0;
        while (i < live && slot_in_use[i]) i++;
        if (i >= live) begin
          r.status = stwim_pkg::ST_NO_FREE;
        end else begin
          slot_in_use[i] = 1'b1;
          slot_owner[i]  = c.entity_id;
          if (c.entity_id[IdW-1]) begin
            r.found_slot = i[SlotIdxW-1:0];
          end else if (!mappable) begin
            slot_in_use[i] = 1'b0;
            r.status       = stwim_pkg::ST_BEYOND;
          end else begin
            id_to_slot[c.entity_id[MapAddrW-1:0]] = i[SlotIdxW-1:0];
            r.found_slot = i[SlotIdxW-1:0];
          end
        end
      end
      stwim_pkg::CMD_FREE: begin
        if (c.slot_index < live) begin
          slot_in_use[c.slot_index] = 1'b0;
          slot_owner[c.slot_index]  = '0;
        end
      end
      stwim_pkg::CMD_SET_ID: begin
        if (c.slot_index < live) begin
          slot_owner[c.slot_index] = c.entity_id;
          if (mappable) begin
            id_to_slot[c.entity_id[MapAddrW-1:0]] = c.slot_index;
          end else if (!c.entity_id[IdW-1]) begin
            r.status = stwim_pkg::ST_BEYOND;
          end
        end
      end
      stwim_pkg::CMD_LOOKUP: begin
        if (c.entity_id[IdW-1]) begin
          r.status = stwim_pkg::ST_NOT_FOUND;
        end else if (!mappable) begin
          r.status = stwim_pkg::ST_BEYOND;
        end else begin
          s = id_to_slot[c.entity_id[MapAddrW-1:0]];
          if (s < live && slot_in_use[s] && slot_owner[s] == c.entity_id) begin
            r.found_slot = s;
          end else begin
            r.status = stwim_pkg::ST_NOT_FOUND;
          end
        end
      end
      stwim_pkg::CMD_NEXT: begin
        if (model_client_role) begin
          r.issued_id = stwim_pkg::ClientId;
        end else begin
          r.issued_id   = next_issue_id;
          next_issue_id = next_issue_id + 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic command_t random_command();
    command_t    c;
    int unsigned live;
    int unsigned pick;
    int unsigned taken [$];
    live = usable_slots();
    for (int unsigned k = 0; k < live; k++) begin
      if (slot_in_use[k]) taken.push_back(k);
    end
    pick = $urandom_range(0, 99);
    if (pick < 25)      c.cmd = stwim_pkg::CMD_ALLOC;
    else if (pick < 50) c.cmd = stwim_pkg::CMD_FREE;
    else if (pick < 60) c.cmd = stwim_pkg::CMD_SET_ID;
    else if (pick < 88) c.cmd = stwim_pkg::CMD_LOOKUP;
    else if (pick < 95) c.cmd = stwim_pkg::CMD_NEXT;
    else                c.cmd = stwim_pkg::cmd_t'($urandom_range(CmdUndefLow, CmdUndefHigh));
    case ($urandom_range(0, 19))
      14: c.entity_id = $urandom_range(0, IdSlots - 1);
      15: c.entity_id = $urandom_range(IdSlots - 4, IdSlots - 1);
      16: c.entity_id = $urandom_range(IdSlots, 4 * IdSlots);
      17: c.entity_id = $urandom();
      18: c.entity_id = $urandom() | 32'h8000_0000;
      19: begin
        case ($urandom_range(0, 3))
          0: c.entity_id = 32'h7FFF_FFFF;
          1: c.entity_id = 32'h8000_0000;
          2: c.entity_id = 32'hFFFF_FFFF;
          default: c.entity_id = IdSlots;
        endcase
      end
      default: c.entity_id = $urandom_range(0, 23);
    endcase
    if (c.cmd == stwim_pkg::CMD_LOOKUP && taken.size() != 0 && $urandom_range(0, 1) == 0) begin
      c.entity_id = slot_owner[taken[$urandom_range(0, taken.size() - 1)]];
    end
    if (live != 0 && $urandom_range(0, 9) < 8) begin
      c.slot_index = SlotIdxW'($urandom_range(0, live - 1));
    end else begin
      c.slot_index = SlotIdxW'($urandom_range(0, SlotsBuilt - 1));
    end
    if (c.cmd == stwim_pkg::CMD_FREE && taken.size() != 0 && $urandom_range(0, 3) != 0) begin
      c.slot_index = SlotIdxW'(taken[$urandom_range(0, taken.size() - 1)]);
    end
    return c;
  endfunction

  function automatic plan_row_t cmd_row(stwim_pkg::cmd_t c, logic [IdW-1:0] id,
                                        logic [SlotIdxW-1:0] idx);
    plan_row_t p;
    p = '0;
    p.command = '{cmd: c, entity_id: id, slot_index: idx};
    return p;
  endfunction

  function automatic plan_row_t checked_row(stwim_pkg::cmd_t c, logic [IdW-1:0] id,
                                            logic [SlotIdxW-1:0] idx,
                                            stwim_pkg::status_t st,
                                            logic [SlotIdxW-1:0] slot,
                                            logic [IdW-1:0] issued);
    plan_row_t p;
    p = cmd_row(c, id, idx);
    p.checked      = 1'b1;
    p.typed_result = '{status: st, found_slot: slot, issued_id: issued};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(stwim_pkg::cfg_index_t i, logic [CfgDataW-1:0] v);
    plan_row_t p;
    p = '0;
    p.is_cfg    = 1'b1;
    p.cfg_index = i;
    p.cfg_data  = v;
    return p;
  endfunction

  task automatic drive_command(command_t c, logic checked, outcome_t typed);
    outcome_t predicted;
    start        = 1'b1;
    cmd_i        = c.cmd;
    entity_id_i  = c.entity_id;
    slot_index_i = c.slot_index;
    do @(posedge clk_i); while (busy);
    predicted = execute_slot_command(c);
    pending_results.push_back(checked ? typed : predicted);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(stwim_pkg::cfg_index_t i, logic [CfgDataW-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_index_i = i;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (i == stwim_pkg::CFG_SLOT_COUNT) begin
      model_slot_count = v;
    end else if (i == stwim_pkg::CFG_CLIENT_ROLE) begin
      model_client_role = v[0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: status %0d slot %0d id %h",
               status_o, found_slot_o, issued_id_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (found_slot_o !== want.found_slot) begin
          $error("found_slot: expected %0d, got %0d", want.found_slot, found_slot_o);
          mismatch_count++;
        end
        if (issued_id_o !== want.issued_id) begin
          $error("issued_id: expected %h, got %h", want.issued_id, issued_id_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [CfgDataW-1:0] count_value;
    logic [CfgDataW-1:0] role_value;
    mismatch_count    = 0;
    cycle_count       = 0;
    rst_ni            = 1'b0;
    start             = 1'b0;
    cmd_i             = '0;
    entity_id_i       = '0;
    slot_index_i      = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    model_slot_count  = stwim_pkg::SlotCountReset;
    model_client_role = 1'b0;
    next_issue_id     = stwim_pkg::IdCounterReset;
    for (int k = 0; k < SlotsBuilt; k++) begin
      slot_in_use[k] = 1'b0;
      slot_owner[k]  = '0;
    end
    for (int k = 0; k < IdSlots; k++) id_to_slot[k] = '0;

    directed_plan.push_back(checked_row(stwim_pkg::CMD_LOOKUP, 32'd0, 6'd0,
                                        stwim_pkg::ST_NOT_FOUND, 6'd0, 32'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_NEXT, 32'd0, 6'd0,
                                        stwim_pkg::ST_OK, 6'd0,
                                        stwim_pkg::IdCounterReset));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_ALLOC, 32'd5, 6'd0,
                                        stwim_pkg::ST_OK, 6'd0, 32'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_ALLOC, 32'h8000_0000, 6'd0,
                                        stwim_pkg::ST_OK, 6'd1, 32'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_ALLOC, IdSlots, 6'd0,
                                        stwim_pkg::ST_BEYOND, 6'd0, 32'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_ALLOC, IdSlots - 1, 6'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_LOOKUP, 32'd5, 6'd0,
                                        stwim_pkg::ST_OK, 6'd0, 32'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_LOOKUP, IdSlots - 1, 6'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 6'd0,
                                        stwim_pkg::ST_BEYOND, 6'd0, 32'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd63,
                                        stwim_pkg::ST_NOT_FOUND, 6'd0, 32'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_SET_ID, 32'd5, 6'd63));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_LOOKUP, 32'd5, 6'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_SET_ID, 32'd2000, 6'd3,
                                        stwim_pkg::ST_BEYOND, 6'd0, 32'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_SET_ID, 32'hFFFF_FFFB, 6'd4));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_FREE, 32'hFFFF_FFFF, 6'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_FREE, 32'd0, 6'd63));
    directed_plan.push_back(checked_row(CmdUndefLow, 32'hFFFF_FFFF, 6'd63,
                                        stwim_pkg::ST_OK, 6'd0, 32'd0));
    directed_plan.push_back(checked_row(CmdUndefHigh, 32'h8000_0000, 6'd0,
                                        stwim_pkg::ST_OK, 6'd0, 32'd0));
    directed_plan.push_back(cfg_row(stwim_pkg::CFG_SLOT_COUNT, 7'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_ALLOC, 32'd9, 6'd0,
                                        stwim_pkg::ST_NO_FREE, 6'd0, 32'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_FREE, 32'd0, 6'd1));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_SET_ID, 32'd9, 6'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_LOOKUP, IdSlots - 1, 6'd0));
    directed_plan.push_back(cfg_row(stwim_pkg::CFG_CLIENT_ROLE, 7'd1));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_NEXT, 32'd0, 6'd0,
                                        stwim_pkg::ST_OK, 6'd0, stwim_pkg::ClientId));
    directed_plan.push_back(cfg_row(stwim_pkg::CFG_SLOT_COUNT, 7'd1));
    directed_plan.push_back(cfg_row(stwim_pkg::CFG_CLIENT_ROLE, 7'd0));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_ALLOC, 32'd12, 6'd0));
    directed_plan.push_back(checked_row(stwim_pkg::CMD_ALLOC, 32'd13, 6'd0,
                                        stwim_pkg::ST_NO_FREE, 6'd0, 32'd0));
    directed_plan.push_back(cfg_row(stwim_pkg::CFG_SLOT_COUNT, 7'd127));
    directed_plan.push_back(cmd_row(stwim_pkg::CMD_NEXT, 32'd0, 6'd0));

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].is_cfg) begin
        wait_idle();
        write_register(directed_plan[r].cfg_index, directed_plan[r].cfg_data);
      end else begin
        sender_gap();
        drive_command(directed_plan[r].command, directed_plan[r].checked,
                      directed_plan[r].typed_result);
      end
    end

    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       count_value = 7'd0;
        1:       count_value = 7'd1;
        2:       count_value = 7'd2;
        3, 4:    count_value = 7'($urandom_range(3, 16));
        5, 6:    count_value = 7'($urandom_range(17, 63));
        7:       count_value = 7'd64;
        8:       count_value = 7'($urandom_range(65, 126));
        default: count_value = 7'd127;
      endcase
      role_value = {6'($urandom_range(0, 63)), 1'($urandom_range(0, 3) == 0)};
      if ($urandom_range(0, 1) == 0) begin
        write_register(stwim_pkg::CFG_SLOT_COUNT, count_value);
        write_register(stwim_pkg::CFG_CLIENT_ROLE, role_value);
      end else begin
        write_register(stwim_pkg::CFG_CLIENT_ROLE, role_value);
        write_register(stwim_pkg::CFG_SLOT_COUNT, count_value);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_register(stwim_pkg::cfg_index_t'($urandom_range(2, 3)),
                       7'($urandom_range(0, 127)));
      end
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        if (phase < RandomPhases - 1) sender_gap();
        drive_command(random_command(), 1'b0, '0);
      end
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stwim_pkg.sv
rtl/slot_table_with_id_map_unit.sv
test/tb_slot_table_with_id_map_unit.sv
